>>> hw/rtl/sorted_priority_queue_unit_defines.svh
// assertion macros for the sorted priority queue unit
// used by the top level, expects i_clk and i_rst_n in scope
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue check failed");

// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue check failed");

`endif

>>> hw/rtl/spq_pkg.sv
// shared types and constants for the sorted priority queue unit
// no dependencies
package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_BITS  = 16;
    localparam int PRIO_BITS = 8;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam logic       ACT_ENQ  = 1'b0;
    localparam logic       ACT_DEQ  = 1'b1;
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_FULL = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    // contents of one cell
    typedef struct packed {
        logic                 valid;
        logic [KEY_BITS-1:0]  key;
        logic [PRIO_BITS-1:0] prio;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic                 enq;
        logic                 deq;
        logic [KEY_BITS-1:0]  key;
        logic [PRIO_BITS-1:0] prio;
    } t_cmd;

endpackage

>>> hw/rtl/spq_cell.sv
// one cell of the sorted chain: holds one entry and trades with its neighbors
// depends on spq_pkg
module spq_cell
    import spq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  t_entry i_prev,
    input  logic   i_prev_lower,
    input  t_entry i_next,
    output t_entry o_entry,
    output logic   o_lower
);

    logic                 r_valid;
    logic [KEY_BITS-1:0]  r_key;
    logic [PRIO_BITS-1:0] r_prio;
    t_entry               n_entry;
    logic                 w_load;

    // this cell yields to the new entry when empty or strictly lower
    assign o_lower = !r_valid || (r_prio < i_cmd.prio);

    // next contents: shift right, take the new entry, or shift left
    always_comb begin
        n_entry = '{valid: r_valid, key: r_key, prio: r_prio};
        w_load  = 1'b0;
        priority if (i_cmd.enq && o_lower) begin
            w_load = 1'b1;
            if (i_prev_lower) begin
                n_entry = i_prev;
            end else begin
                n_entry = '{valid: 1'b1, key: i_cmd.key, prio: i_cmd.prio};
            end
        end else if (i_cmd.deq) begin
            w_load  = 1'b1;
            n_entry = i_next;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= n_entry.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_key  <= n_entry.key;
            r_prio <= n_entry.prio;
        end
    end

    assign o_entry = '{valid: r_valid, key: r_key, prio: r_prio};

endmodule

>>> hw/rtl/sorted_priority_queue_unit.sv
// sorted priority queue unit: 16 entries in a chain of cells, front at cell 0
// one transaction per cycle; result strobed on o_done the cycle after start
// throughput 1 item per cycle, as all cells shift together on each accepted transaction
// busy stays low; the receiver cannot stall and each result shows for one cycle
// reset clears the count and the cell valid bits; no clearing pass is needed
// depends on spq_pkg, spq_cell and sorted_priority_queue_unit_defines.svh
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_action,
    input  logic [KEY_BITS-1:0]  i_item_key,
    input  logic [PRIO_BITS-1:0] i_item_priority,
    output logic                 o_done,
    output logic [KEY_BITS-1:0]  o_front_key,
    output logic                 o_front_valid,
    output logic [CNT_W-1:0]     o_entry_count,
    output logic [1:0]           o_error_code
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    logic [1:0]       r_error;
    logic [1:0]       n_error;
    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic             w_enq_full;
    t_cmd             w_cmd;
    t_entry           w_entry [DEPTH];
    logic             w_lower [DEPTH];
    logic [DEPTH-1:0] w_valid;

    assign busy       = 1'b0;
    assign w_accept   = start && !busy;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_enq_full = w_accept && (i_action == ACT_ENQ) && w_full;

    // decode the transaction into a cell command
    always_comb begin
        w_cmd.enq = w_accept && (i_action == ACT_ENQ) && !w_full;
        w_cmd.deq = w_accept && (i_action == ACT_DEQ) && !w_empty;
        w_cmd.key  = i_item_key;
        w_cmd.prio = i_item_priority;
        n_count = r_count;
        n_error = ERR_NONE;
        unique case (i_action)
            ACT_ENQ: begin
                if (w_full) n_error = ERR_FULL;
                else        n_count = r_count + 1'b1;
            end
            ACT_DEQ: begin
                if (w_empty) n_error = ERR_EMPTY;
                else         n_count = r_count - 1'b1;
            end
            default: n_error = ERR_NONE;
        endcase
    end

    // the chain of cells
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_entry w_prev;
        logic   w_prev_lower;
        t_entry w_next;
        if (gi == 0) begin : g_head
            assign w_prev       = '0;
            assign w_prev_lower = 1'b0;
        end else begin : g_body
            assign w_prev       = w_entry[gi-1];
            assign w_prev_lower = w_lower[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_entry[gi+1];
        end
        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_prev      (w_prev),
            .i_prev_lower(w_prev_lower),
            .i_next      (w_next),
            .o_entry     (w_entry[gi]),
            .o_lower     (w_lower[gi])
        );
        assign w_valid[gi] = w_entry[gi].valid;
    end

    // count and result control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_accept;
            if (w_accept) r_count <= n_count;
        end
    end

    // error code of the last transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) r_error <= n_error;
    end

    // result ports
    assign o_done        = r_done;
    assign o_front_valid = w_entry[0].valid;
    assign o_front_key   = w_entry[0].valid ? w_entry[0].key : '0;
    assign o_entry_count = r_count;
    assign o_error_code  = r_error;

    // the count matches the occupied cells
    `SPQ_ASSERT_NOW(a_count_cells, 1'b1, $countones(w_valid) == r_count)

    // occupied cells are packed at the front and sorted by priority
    for (genvar gj = 0; gj < DEPTH - 1; gj++) begin : g_chk
        logic w_in_order;
        assign w_in_order = w_valid[gj] && (w_entry[gj].prio >= w_entry[gj+1].prio);
        `SPQ_ASSERT_NOW(a_sorted, w_valid[gj+1], w_in_order)
    end

    // an accepted enqueue into a non-full queue grows the count by one
    `SPQ_ASSERT_NEXT(a_enq_grow, w_cmd.enq, (r_count == $past(r_count) + 1'b1) && (r_error == ERR_NONE))

    // an enqueue into a full queue leaves the count and flags the drop
    `SPQ_ASSERT_NEXT(a_enq_full, w_enq_full, (r_count == $past(r_count)) && (r_error == ERR_FULL))

endmodule

>>> verif/tb.sv
// self-checking testbench for the sorted priority queue unit
// drives enqueue/dequeue transactions and checks every strobed result against a shadow queue
// depends on spq_pkg and sorted_priority_queue_unit
module tb;
    import spq_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASE  = 338;

    // one queued command for the driver
    typedef struct {
        logic                 act;
        logic [KEY_BITS-1:0]  key;
        logic [PRIO_BITS-1:0] prio;
        int                   idle_pct;
        bit                   hold;
    } t_cmd_item;

    // queue status reported after one transaction
    typedef struct {
        logic [KEY_BITS-1:0] front_key;
        logic                front_valid;
        logic [CNT_W-1:0]    entry_count;
        logic [1:0]          error_code;
    } t_status;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_action = ACT_ENQ;
    logic [KEY_BITS-1:0]  i_item_key = '0;
    logic [PRIO_BITS-1:0] i_item_priority = '0;
    logic                 o_done;
    logic [KEY_BITS-1:0]  o_front_key;
    logic                 o_front_valid;
    logic [CNT_W-1:0]     o_entry_count;
    logic [1:0]           o_error_code;

    t_cmd_item cmd_backlog[$];
    t_status   status_due[$];
    int        err_count = 0;
    int        cycle_count = 0;

    // shadow copy of the sorted slots
    logic [KEY_BITS-1:0]  shadow_keys[DEPTH];
    logic [PRIO_BITS-1:0] shadow_prios[DEPTH];
    int                   shadow_count = 0;

    sorted_priority_queue_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_item_key      (i_item_key),
        .i_item_priority (i_item_priority),
        .o_done          (o_done),
        .o_front_key     (o_front_key),
        .o_front_valid   (o_front_valid),
        .o_entry_count   (o_entry_count),
        .o_error_code    (o_error_code)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // apply one transaction to the shadow queue and return the status it leaves
    function automatic t_status queue_after_step(logic act, logic [KEY_BITS-1:0] key,
                                                 logic [PRIO_BITS-1:0] prio);
        t_status st;
        int      pos;
        st.error_code = ERR_NONE;
        if (act == ACT_ENQ) begin
            if (shadow_count >= DEPTH) begin
                st.error_code = ERR_FULL;
            end else begin
                // new entry goes behind every entry of equal or higher priority
                pos = 0;
                while (pos < shadow_count && shadow_prios[pos] >= prio)
                    pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_keys[i]  = shadow_keys[i-1];
                    shadow_prios[i] = shadow_prios[i-1];
                end
                shadow_keys[pos]  = key;
                shadow_prios[pos] = prio;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                st.error_code = ERR_EMPTY;
            end else begin
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_keys[i-1]  = shadow_keys[i];
                    shadow_prios[i-1] = shadow_prios[i];
                end
                shadow_count--;
            end
        end
        st.front_valid = (shadow_count > 0);
        st.front_key   = (shadow_count > 0) ? shadow_keys[0] : '0;
        st.entry_count = shadow_count[CNT_W-1:0];
        return st;
    endfunction

    task automatic add_cmd(logic act, logic [KEY_BITS-1:0] key, logic [PRIO_BITS-1:0] prio,
                           int idle_pct, bit hold);
        t_cmd_item c;
        c.act      = act;
        c.key      = key;
        c.prio     = prio;
        c.idle_pct = idle_pct;
        c.hold     = hold;
        cmd_backlog.push_back(c);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // driver: record accepted transaction, then present the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                status_due.push_back(queue_after_step(i_action, i_item_key, i_item_priority));
                void'(cmd_backlog.pop_front());
            end
            if (cmd_backlog.size() == 0) begin
                start <= 1'b0;
            end else if (cmd_backlog[0].hold && status_due.size() != 0) begin
                // hold off until every outstanding result has come back
                start <= 1'b0;
            end else if ($urandom_range(99) < cmd_backlog[0].idle_pct) begin
                start <= 1'b0;
            end else begin
                cmd_backlog[0].hold = 1'b0;
                start           <= 1'b1;
                i_action        <= cmd_backlog[0].act;
                i_item_key      <= cmd_backlog[0].key;
                i_item_priority <= cmd_backlog[0].prio;
            end
        end
    end

    // monitor: every strobed result must match the oldest expectation
    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && o_done) begin
            if (status_due.size() == 0) begin
                $display("%0t: result with none expected, actual key %0h count %0d err %0d",
                         $time, o_front_key, o_entry_count, o_error_code);
                err_count++;
            end else begin
                want = status_due.pop_front();
                check_field("front_key", 32'(want.front_key), 32'(o_front_key));
                check_field("front_valid", 32'(want.front_valid), 32'(o_front_valid));
                check_field("entry_count", 32'(want.entry_count), 32'(o_entry_count));
                check_field("error_code", 32'(want.error_code), 32'(o_error_code));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int phase_idle[4];
        int enq_pct;
        int run_left;
        int pick;
        logic [PRIO_BITS-1:0] prio;

        phase_idle[0] = 0;
        phase_idle[1] = 50;
        phase_idle[2] = 17;
        phase_idle[3] = 0;

        // directed: empty dequeue, extremes, single-entry removal, ties, fill, full enqueue
        add_cmd(ACT_DEQ, 16'h0000, 8'h00, 0, 1'b0);
        add_cmd(ACT_ENQ, 16'hFFFF, 8'hFF, 0, 1'b0);
        add_cmd(ACT_DEQ, 16'hFFFF, 8'hFF, 0, 1'b0);
        add_cmd(ACT_ENQ, 16'h0000, 8'h00, 0, 1'b0);
        add_cmd(ACT_ENQ, 16'h1111, 8'h80, 0, 1'b0);
        add_cmd(ACT_ENQ, 16'h2222, 8'h80, 0, 1'b0);
        add_cmd(ACT_ENQ, 16'h3333, 8'h80, 0, 1'b0);
        for (int n = 0; n < 12; n++) begin
            case (n % 4)
                0: prio = 8'h00;
                1: prio = 8'h80;
                2: prio = 8'hFF;
                default: prio = PRIO_BITS'($urandom_range(255));
            endcase
            add_cmd(ACT_ENQ, KEY_BITS'($urandom), prio, 0, 1'b0);
        end
        add_cmd(ACT_ENQ, 16'hA5A5, 8'hFF, 0, 1'b0);
        for (int n = 0; n < 4; n++)
            add_cmd(ACT_DEQ, KEY_BITS'($urandom), PRIO_BITS'($urandom), 0, 1'b0);

        // random: runs biased toward filling, draining or neither, to reach full and empty
        for (int p = 0; p < 4; p++) begin
            run_left = 0;
            enq_pct  = 50;
            for (int n = 0; n < RAND_PHASE; n++) begin
                if (run_left == 0) begin
                    run_left = $urandom_range(20, 60);
                    pick     = $urandom_range(2);
                    enq_pct  = (pick == 0) ? 85 : (pick == 1) ? 15 : 50;
                end
                run_left--;
                pick = $urandom_range(99);
                if (pick < 60)
                    prio = PRIO_BITS'($urandom_range(3));
                else if (pick < 70)
                    prio = $urandom_range(1) ? 8'hFF : 8'h00;
                else
                    prio = PRIO_BITS'($urandom_range(255));
                add_cmd(($urandom_range(99) < enq_pct) ? ACT_ENQ : ACT_DEQ,
                        KEY_BITS'($urandom), prio, phase_idle[p], n == 0);
            end
        end

        // reset, then let the driver run
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || start)
            @(posedge i_clk);
        while (status_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sorted_priority_queue_unit.f
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_unit.sv
verif/tb.sv
